FILE: design/okxyz_pkg.sv
// ----------------------------------------------------------------------------
// okxyz_pkg
// Shared widths, types and matrix constants for the Oklab to XYZ pipeline.
// ----------------------------------------------------------------------------
package okxyz_pkg;

    // Fixed-point format of every sample
    localparam int FRAC_BITS = 14;

    localparam int LANES   = 3;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int DATA_W  = LANES * IN_W;

    // Coefficients are integers in units of 1e-8
    localparam int COEF_W  = 29;
    // Matrix accumulators, wide enough for both matrix passes
    localparam int ACC_W   = 50;
    // Rounded quotient of an accumulator by 1e8
    localparam int QUO_W   = 26;
    // Nonlinear LMS sample, square, cube and linear LMS sample
    localparam int NL_W    = 18;
    localparam int SQ_W    = 34;
    localparam int CUBE_W  = SQ_W + NL_W;
    localparam int LMS_W   = 22;
    localparam int CUBE_SHIFT = 2 * FRAC_BITS;

    // Divide by 1e8 = 2^8 * 390625: shift first, then reciprocal multiply
    localparam longint DEC_ONE   = 100000000;
    localparam int     DIV_SHIFT = 8;
    localparam int     DIV_ODD   = 390625;
    localparam int     DIV_ODD_W = 19;
    // Offset in quotient units that keeps the shifted dividend positive
    localparam int     BIAS_Q    = 2 ** 23;
    localparam int     BIAS_W    = 52;
    localparam logic [BIAS_W-1:0] DIV_BIAS =
        BIAS_W'(DEC_ONE / 2 + longint'(BIAS_Q) * DEC_ONE);
    // Biased, shifted dividend and its split for the partial products
    localparam int     Y_W       = 43;
    localparam int     Y_SPLIT   = 23;
    // floor(2^Y_W / DIV_ODD)
    localparam int     RECIP_W   = 25;
    localparam logic [RECIP_W-1:0] RECIP = 25'd22517998;
    localparam int     QE_W      = RECIP_W;
    // Remainder is below twice DIV_ODD
    localparam int     REM_W     = 21;

    // Registered stages from input beat to output beat
    localparam int PIPE_DEPTH = 18;

    typedef logic signed [IN_W-1:0]   sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [QUO_W-1:0]  quo_t;
    typedef logic signed [NL_W-1:0]   nl_t;
    typedef logic signed [LMS_W-1:0]  lms_t;

    // Control that travels down the pipeline with each beat
    typedef struct packed {
        logic vld;
        logic eol;
    } okxyz_tag_t;

    localparam quo_t OUT_MAX = quo_t'(32767);
    localparam quo_t OUT_MIN = quo_t'(-32768);

    // Weight of L in every row of the inverse M2 matrix
    localparam coef_t L_COEF = coef_t'(DEC_ONE);

    // Inverse M2: rows l', m', s'; columns a, b
    localparam coef_t M2_INV [LANES][2] = '{
        '{coef_t'(39633779),  coef_t'(21580376)},
        '{coef_t'(-10556134), coef_t'(-6385417)},
        '{coef_t'(-8948418),  coef_t'(-129148554)}
    };

    // Inverse M1: rows X, Y, Z; columns l, m, s
    localparam coef_t M1_INV [LANES][LANES] = '{
        '{coef_t'(122701385), coef_t'(-55779998), coef_t'(28125615)},
        '{coef_t'(-4058018),  coef_t'(111225687), coef_t'(-7167668)},
        '{coef_t'(-7638128),  coef_t'(-42148198), coef_t'(158616322)}
    };

endpackage

FILE: design/okxyz_lab_mac.sv
// ----------------------------------------------------------------------------
// okxyz_lab_mac
// Inverse M2 matrix pass: products in one stage, three-term sums in the next.
// ----------------------------------------------------------------------------
module okxyz_lab_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  okxyz_pkg::okxyz_tag_t in_tag,
    output logic                  in_ready,
    input  okxyz_pkg::sample_t    lightness,
    input  okxyz_pkg::sample_t    green_red,
    input  okxyz_pkg::sample_t    blue_yellow,
    output okxyz_pkg::okxyz_tag_t out_tag,
    input  logic                  out_ready,
    output okxyz_pkg::acc_t       acc [okxyz_pkg::LANES]
);
    import okxyz_pkg::*;

    localparam int STAGES = 2;
    localparam int PROD_W = IN_W + COEF_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] eol_reg;
    logic [STAGES-1:0] eol_next;
    logic [STAGES-1:0] adv;

    logic signed [PROD_W-1:0] pl_reg;
    logic signed [PROD_W-1:0] pl_next;
    logic signed [PROD_W-1:0] pa_reg  [LANES];
    logic signed [PROD_W-1:0] pa_next [LANES];
    logic signed [PROD_W-1:0] pb_reg  [LANES];
    logic signed [PROD_W-1:0] pb_next [LANES];
    acc_t                     acc_reg  [LANES];
    acc_t                     acc_next [LANES];

    // Advance a stage when it is empty or the one below it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Move valid and end-of-line bits with the data
    always_comb
    begin
        vld_next = vld_reg;
        eol_next = eol_reg;
        if (adv[0])
        begin
            vld_next[0] = in_tag.vld;
            eol_next[0] = in_tag.eol;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
                eol_next[k] = eol_reg[k-1];
            end
        end
    end

    // Form the products and the row sums
    always_comb
    begin
        pl_next = lightness * L_COEF;
        for (int i = 0; i < LANES; i++)
        begin
            pa_next[i]  = green_red * M2_INV[i][0];
            pb_next[i]  = blue_yellow * M2_INV[i][1];
            acc_next[i] = ACC_W'(pl_reg) + ACC_W'(pa_reg[i]) + ACC_W'(pb_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg <= eol_next;
        if (adv[0])
        begin
            pl_reg <= pl_next;
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (adv[0])
            begin
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
            end
            if (adv[1])
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_tag.vld = vld_reg[STAGES-1];
    assign out_tag.eol = eol_reg[STAGES-1];
    assign acc         = acc_reg;

endmodule

FILE: design/okxyz_rdiv.sv
// ----------------------------------------------------------------------------
// okxyz_rdiv
// Three-lane rounded division by 1e8, ties toward plus infinity. The
// dividend is biased positive and shifted, then divided by 390625 through a
// split reciprocal multiply and a one-step remainder correction.
// ----------------------------------------------------------------------------
module okxyz_rdiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  okxyz_pkg::okxyz_tag_t in_tag,
    output logic                  in_ready,
    input  okxyz_pkg::acc_t       dividend [okxyz_pkg::LANES],
    output okxyz_pkg::okxyz_tag_t out_tag,
    input  logic                  out_ready,
    output okxyz_pkg::quo_t       quotient [okxyz_pkg::LANES]
);
    import okxyz_pkg::*;

    localparam int STAGES  = 5;
    localparam int HI_W    = Y_W - Y_SPLIT;
    localparam int PHI_W   = HI_W + RECIP_W;
    localparam int PLO_W   = Y_SPLIT + RECIP_W;
    localparam int SUM_W   = Y_W + RECIP_W;
    localparam int QPROD_W = QE_W + DIV_ODD_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] eol_reg;
    logic [STAGES-1:0] eol_next;
    logic [STAGES-1:0] adv;

    logic [BIAS_W-1:0]  biased   [LANES];
    logic [SUM_W-1:0]   sum      [LANES];
    logic [QPROD_W-1:0] qprod    [LANES];

    logic [Y_W-1:0]     y0_reg    [LANES];
    logic [Y_W-1:0]     y0_next   [LANES];
    logic [PHI_W-1:0]   phi_reg   [LANES];
    logic [PHI_W-1:0]   phi_next  [LANES];
    logic [PLO_W-1:0]   plo_reg   [LANES];
    logic [PLO_W-1:0]   plo_next  [LANES];
    logic [REM_W-1:0]   ylo1_reg  [LANES];
    logic [REM_W-1:0]   ylo1_next [LANES];
    logic [QE_W-1:0]    qe_reg    [LANES];
    logic [QE_W-1:0]    qe_next   [LANES];
    logic [REM_W-1:0]   ylo2_reg  [LANES];
    logic [REM_W-1:0]   ylo2_next [LANES];
    logic [QE_W-1:0]    qe3_reg   [LANES];
    logic [QE_W-1:0]    qe3_next  [LANES];
    logic [REM_W-1:0]   rem_reg   [LANES];
    logic [REM_W-1:0]   rem_next  [LANES];
    quo_t               quo_reg   [LANES];
    quo_t               quo_next  [LANES];

    // Advance a stage when it is empty or the one below it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Move valid and end-of-line bits with the data
    always_comb
    begin
        vld_next = vld_reg;
        eol_next = eol_reg;
        if (adv[0])
        begin
            vld_next[0] = in_tag.vld;
            eol_next[0] = in_tag.eol;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
                eol_next[k] = eol_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            // Add half the divisor and the bias, drop the power-of-two factor
            biased[i]  = BIAS_W'(dividend[i]) + DIV_BIAS;
            y0_next[i] = biased[i][DIV_SHIFT +: Y_W];

            // Reciprocal partial products on the upper and lower halves
            phi_next[i]  = PHI_W'(y0_reg[i][Y_W-1:Y_SPLIT]) * PHI_W'(RECIP);
            plo_next[i]  = PLO_W'(y0_reg[i][Y_SPLIT-1:0]) * PLO_W'(RECIP);
            ylo1_next[i] = y0_reg[i][REM_W-1:0];

            // Combine them; the estimate is the true quotient or one below
            sum[i]       = {phi_reg[i], {Y_SPLIT{1'b0}}} + SUM_W'(plo_reg[i]);
            qe_next[i]   = sum[i][SUM_W-1:Y_W];
            ylo2_next[i] = ylo1_reg[i];

            // Remainder of the estimate, only its low bits matter
            qprod[i]    = QPROD_W'(qe_reg[i]) * QPROD_W'(DIV_ODD);
            rem_next[i] = ylo2_reg[i] - qprod[i][REM_W-1:0];
            qe3_next[i] = qe_reg[i];

            // Correct the estimate and remove the bias
            quo_next[i] = quo_t'({1'b0, qe3_reg[i]}) - quo_t'(BIAS_Q);
            if (rem_reg[i] >= REM_W'(DIV_ODD))
            begin
                quo_next[i] = quo_next[i] + quo_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg <= eol_next;
        for (int i = 0; i < LANES; i++)
        begin
            if (adv[0])
            begin
                y0_reg[i] <= y0_next[i];
            end
            if (adv[1])
            begin
                phi_reg[i]  <= phi_next[i];
                plo_reg[i]  <= plo_next[i];
                ylo1_reg[i] <= ylo1_next[i];
            end
            if (adv[2])
            begin
                qe_reg[i]   <= qe_next[i];
                ylo2_reg[i] <= ylo2_next[i];
            end
            if (adv[3])
            begin
                rem_reg[i] <= rem_next[i];
                qe3_reg[i] <= qe3_next[i];
            end
            if (adv[4])
            begin
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_tag.vld = vld_reg[STAGES-1];
    assign out_tag.eol = eol_reg[STAGES-1];
    assign quotient    = quo_reg;

endmodule

FILE: design/okxyz_cube.sv
// ----------------------------------------------------------------------------
// okxyz_cube
// Cubes the three nonlinear LMS samples: square, multiply, then round away
// the doubled fraction bits.
// ----------------------------------------------------------------------------
module okxyz_cube (
    input  logic                  clk,
    input  logic                  rst_n,
    input  okxyz_pkg::okxyz_tag_t in_tag,
    output logic                  in_ready,
    input  okxyz_pkg::quo_t       nl_lms [okxyz_pkg::LANES],
    output okxyz_pkg::okxyz_tag_t out_tag,
    input  logic                  out_ready,
    output okxyz_pkg::lms_t       lin_lms [okxyz_pkg::LANES]
);
    import okxyz_pkg::*;

    localparam int STAGES  = 3;
    localparam int SQF_W   = 2 * NL_W;
    localparam logic signed [CUBE_W-1:0] CUBE_HALF =
        CUBE_W'(longint'(1) << (CUBE_SHIFT - 1));

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] eol_reg;
    logic [STAGES-1:0] eol_next;
    logic [STAGES-1:0] adv;

    logic signed [SQF_W-1:0]  sq_full [LANES];
    logic signed [CUBE_W-1:0] rnd     [LANES];
    logic signed [CUBE_W-1:0] shifted [LANES];

    nl_t                      p_reg     [LANES];
    nl_t                      p_next    [LANES];
    logic signed [SQ_W-1:0]   sq_reg    [LANES];
    logic signed [SQ_W-1:0]   sq_next   [LANES];
    logic signed [CUBE_W-1:0] cube_reg  [LANES];
    logic signed [CUBE_W-1:0] cube_next [LANES];
    lms_t                     lms_reg   [LANES];
    lms_t                     lms_next  [LANES];

    // Advance a stage when it is empty or the one below it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Move valid and end-of-line bits with the data
    always_comb
    begin
        vld_next = vld_reg;
        eol_next = eol_reg;
        if (adv[0])
        begin
            vld_next[0] = in_tag.vld;
            eol_next[0] = in_tag.eol;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
                eol_next[k] = eol_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            // Nonlinear sample fits the narrow width; square it
            p_next[i]  = nl_t'(nl_lms[i][NL_W-1:0]);
            sq_full[i] = p_next[i] * p_next[i];
            sq_next[i] = sq_full[i][SQ_W-1:0];

            // Third factor
            cube_next[i] = sq_reg[i] * p_reg[i];

            // Round to nearest, ties up
            rnd[i]      = cube_reg[i] + CUBE_HALF;
            shifted[i]  = rnd[i] >>> CUBE_SHIFT;
            lms_next[i] = shifted[i][LMS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg <= eol_next;
        for (int i = 0; i < LANES; i++)
        begin
            if (adv[0])
            begin
                p_reg[i]  <= p_next[i];
                sq_reg[i] <= sq_next[i];
            end
            if (adv[1])
            begin
                cube_reg[i] <= cube_next[i];
            end
            if (adv[2])
            begin
                lms_reg[i] <= lms_next[i];
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_tag.vld = vld_reg[STAGES-1];
    assign out_tag.eol = eol_reg[STAGES-1];
    assign lin_lms     = lms_reg;

endmodule

FILE: design/okxyz_xyz_mac.sv
// ----------------------------------------------------------------------------
// okxyz_xyz_mac
// Inverse M1 matrix pass: nine products in one stage, row sums in the next.
// ----------------------------------------------------------------------------
module okxyz_xyz_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  okxyz_pkg::okxyz_tag_t in_tag,
    output logic                  in_ready,
    input  okxyz_pkg::lms_t       lin_lms [okxyz_pkg::LANES],
    output okxyz_pkg::okxyz_tag_t out_tag,
    input  logic                  out_ready,
    output okxyz_pkg::acc_t       acc [okxyz_pkg::LANES]
);
    import okxyz_pkg::*;

    localparam int STAGES = 2;
    localparam int PROD_W = LMS_W + COEF_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] eol_reg;
    logic [STAGES-1:0] eol_next;
    logic [STAGES-1:0] adv;

    logic signed [PROD_W-1:0] prod_reg  [LANES][LANES];
    logic signed [PROD_W-1:0] prod_next [LANES][LANES];
    acc_t                     acc_reg   [LANES];
    acc_t                     acc_next  [LANES];

    // Advance a stage when it is empty or the one below it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Move valid and end-of-line bits with the data
    always_comb
    begin
        vld_next = vld_reg;
        eol_next = eol_reg;
        if (adv[0])
        begin
            vld_next[0] = in_tag.vld;
            eol_next[0] = in_tag.eol;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
                eol_next[k] = eol_reg[k-1];
            end
        end
    end

    // Form the products and the row sums; sums stay inside the accumulator
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                prod_next[i][j] = lin_lms[j] * M1_INV[i][j];
            end
            acc_next[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                        + ACC_W'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg <= eol_next;
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                if (adv[0])
                begin
                    prod_reg[i][j] <= prod_next[i][j];
                end
            end
            if (adv[1])
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_tag.vld = vld_reg[STAGES-1];
    assign out_tag.eol = eol_reg[STAGES-1];
    assign acc         = acc_reg;

endmodule

FILE: design/oklab_to_xyz_pixel_top.sv
// Throughput: one pixel per cycle while the output is not stalled; the two
// five-stage dividers by 1e8 and the three-stage cube unit, with the matrix
// passes and the output stage, set the depth, and every stage takes a beat
// a cycle unless the stage below it stalls. A stalled output stage holds its
// beat while empty stages upstream fill. Reset (rst_n low, asynchronous)
// clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// oklab_to_xyz_pixel_top
// Oklab to D65 CIE XYZ pixel converter: inverse M2 pass, divide, cube,
// inverse M1 pass, divide, saturate.
// ----------------------------------------------------------------------------
module oklab_to_xyz_pixel_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] lightness, [31:16] green_red, [47:32] blue_yellow
    input  logic [okxyz_pkg::DATA_W-1:0]  s_axis_tdata,
    // line_end
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] x_value, [31:16] y_value, [47:32] z_value
    output logic [okxyz_pkg::DATA_W-1:0]  m_axis_tdata,
    // line_end_out
    output logic                          m_axis_tlast
);
    import okxyz_pkg::*;

    okxyz_tag_t in_tag;
    okxyz_tag_t lab_tag;
    okxyz_tag_t div1_tag;
    okxyz_tag_t cube_tag;
    okxyz_tag_t xyz_tag;
    okxyz_tag_t div2_tag;

    logic lab_ready;
    logic div1_ready;
    logic cube_ready;
    logic xyz_ready;
    logic div2_ready;
    logic out_adv;

    sample_t lab_l;
    sample_t lab_a;
    sample_t lab_b;
    acc_t    lab_acc  [LANES];
    quo_t    nl_lms   [LANES];
    lms_t    lin_lms  [LANES];
    acc_t    xyz_acc  [LANES];
    quo_t    xyz_quo  [LANES];

    sample_t sat_val  [LANES];
    sample_t res_reg  [LANES];
    sample_t res_next [LANES];
    logic    out_vld_reg;
    logic    out_vld_next;
    logic    out_eol_reg;
    logic    out_eol_next;

    // Unpack the input beat
    assign lab_l      = s_axis_tdata[0 +: IN_W];
    assign lab_a      = s_axis_tdata[IN_W +: IN_W];
    assign lab_b      = s_axis_tdata[2*IN_W +: IN_W];
    assign in_tag.vld = s_axis_tvalid;
    assign in_tag.eol = s_axis_tlast;
    assign s_axis_tready = lab_ready;

    okxyz_lab_mac u_lab_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_tag      (in_tag),
        .in_ready    (lab_ready),
        .lightness   (lab_l),
        .green_red   (lab_a),
        .blue_yellow (lab_b),
        .out_tag     (lab_tag),
        .out_ready   (div1_ready),
        .acc         (lab_acc)
    );

    okxyz_rdiv u_div_lms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (lab_tag),
        .in_ready  (div1_ready),
        .dividend  (lab_acc),
        .out_tag   (div1_tag),
        .out_ready (cube_ready),
        .quotient  (nl_lms)
    );

    okxyz_cube u_cube (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (div1_tag),
        .in_ready  (cube_ready),
        .nl_lms    (nl_lms),
        .out_tag   (cube_tag),
        .out_ready (xyz_ready),
        .lin_lms   (lin_lms)
    );

    okxyz_xyz_mac u_xyz_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (cube_tag),
        .in_ready  (xyz_ready),
        .lin_lms   (lin_lms),
        .out_tag   (xyz_tag),
        .out_ready (div2_ready),
        .acc       (xyz_acc)
    );

    okxyz_rdiv u_div_xyz (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (xyz_tag),
        .in_ready  (div2_ready),
        .dividend  (xyz_acc),
        .out_tag   (div2_tag),
        .out_ready (out_adv),
        .quotient  (xyz_quo)
    );

    // Output stage: load when empty or when the current beat is taken
    assign out_adv = !out_vld_reg || m_axis_tready;

    // Saturate to the sample range
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (xyz_quo[i] > OUT_MAX)
            begin
                sat_val[i] = sample_t'(OUT_MAX);
            end
            else if (xyz_quo[i] < OUT_MIN)
            begin
                sat_val[i] = sample_t'(OUT_MIN);
            end
            else
            begin
                sat_val[i] = xyz_quo[i][OUT_W-1:0];
            end
            res_next[i] = out_adv ? sat_val[i] : res_reg[i];
        end
        out_vld_next = out_adv ? div2_tag.vld : out_vld_reg;
        out_eol_next = out_adv ? div2_tag.eol : out_eol_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_eol_reg <= out_eol_next;
        for (int i = 0; i < LANES; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_eol_reg;
    assign m_axis_tdata  = {res_reg[2], res_reg[1], res_reg[0]};

endmodule

FILE: design/okxyz_checker.sv
// ----------------------------------------------------------------------------
// okxyz_checker
// Port-level checks on the pixel converter: beat accounting, reset, output
// hold under stall and readiness when the output is empty.
// ----------------------------------------------------------------------------
module okxyz_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [okxyz_pkg::DATA_W-1:0] s_axis_tdata,
    input logic                         s_axis_tlast,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [okxyz_pkg::DATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast
);
    import okxyz_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic             s_fire;
    logic             m_fire;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // Track beats accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_fire && !m_fire)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (m_fire && !s_fire)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // No output beat without a pixel in flight
    a_no_extra_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_fire |-> cnt_reg != '0)
        else $error("output beat without a matching input beat");

    // Pixels in flight never exceed the pipeline depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    // Reset empties the output by the next edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // An empty output stage means the pipeline can take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

endmodule

bind oklab_to_xyz_pixel_top okxyz_checker u_okxyz_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
